@@ src/pwm_capture_duty_meter_macros.svh @@
// assertion macros for the pwm capture duty meter
// used by the modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef PWM_CAPTURE_DUTY_METER_MACROS_SVH
`define PWM_CAPTURE_DUTY_METER_MACROS_SVH

`ifndef SYNTHESIS
`define PCDM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PCDM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PCDM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCDM_ASSERT(name, prop, msg)
`define PCDM_ASSERT_IMP(name, ante, cons, msg)
`define PCDM_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ src/pcdm_pkg.sv @@
// shared types and constants of the pwm capture duty meter
// no dependencies
package pcdm_pkg;

  localparam int unsigned OUT_W       = 32;
  localparam int unsigned TPT_W       = 16;
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PROD_W      = OUT_W + TPT_W;
  localparam int unsigned DIV_STEPS   = DUTY_W;

  localparam logic [TPT_W-1:0]  TPT_RESET    = 16'd64;
  localparam logic [OUT_W-1:0]  SAT_MAX      = 32'hFFFF_FFFF;
  localparam logic [DUTY_W-1:0] PERCENT_FULL = 7'd100;

  typedef enum logic [0:0] {
    REG_TIME_PER_TICK = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT_START = 2'd0,
    PH_WAIT_FALL  = 2'd1,
    PH_WAIT_CLOSE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_MUL_ON  = 3'd1,
    ST_MUL_PER = 3'd2,
    ST_DIV     = 3'd3,
    ST_FIN     = 3'd4
  } back_state_e;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

@@ src/pcdm_queue.sv @@
// two-entry queue of captured periods between front and back
// depends on pcdm_pkg
`include "pwm_capture_duty_meter_macros.svh"

module pcdm_queue
  import pcdm_pkg::*;
#(
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output queue_stat_t       stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));

  `PCDM_ASSERT_IMP(a_no_push_full, push_i && !pop_i, !stat_o.full, "push into full queue")
  `PCDM_ASSERT_IMP(a_no_pop_empty, pop_i, !stat_o.empty, "pop from empty queue")
  `PCDM_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

@@ src/pcdm_front.sv @@
// front part: tick counter and edge classification, pushes finished periods
// depends on pcdm_pkg
module pcdm_front
  import pcdm_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic                    edge_rising_i,
  input  queue_stat_t             queue_stat_i,
  output logic                    push_o,
  output logic [2*TICK_WIDTH-1:0] push_data_o
);

  phase_e                phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [TICK_WIDTH-1:0] start_q, start_d;
  logic [TICK_WIDTH-1:0] high_q, high_d;
  logic [TICK_WIDTH-1:0] span;
  logic                  accept;

  assign in_ready_o = !queue_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign span       = tick_q - start_q;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    start_d = start_q;
    high_d  = high_q;
    push_o  = 1'b0;
    if (accept) begin
      if (!mode_i) begin
        tick_d = tick_q + 1'b1;
      end else begin
        case (phase_q)
          PH_WAIT_FALL: begin
            if (!edge_rising_i) begin
              high_d  = span;
              phase_d = PH_WAIT_CLOSE;
            end
          end
          PH_WAIT_CLOSE: begin
            if (edge_rising_i) begin
              push_o  = 1'b1;
              start_d = tick_q;
              phase_d = PH_WAIT_FALL;
            end
          end
          default: begin
            if (edge_rising_i) begin
              start_d = tick_q;
              phase_d = PH_WAIT_FALL;
            end
          end
        endcase
      end
    end
  end

  // period span in the upper half, high span in the lower half
  assign push_data_o = {span, high_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_START;
      tick_q  <= '0;
      start_q <= '0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      start_q <= start_d;
      high_q  <= high_d;
    end
  end

endmodule

@@ src/pcdm_back.sv @@
// back part: scaling with saturation, duty division and the output register
// depends on pcdm_pkg
`include "pwm_capture_duty_meter_macros.svh"

module pcdm_back
  import pcdm_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [TPT_W-1:0]        time_per_tick_i,
  input  queue_stat_t             queue_stat_i,
  input  logic [2*TICK_WIDTH-1:0] pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_W-1:0]        on_time_o,
  output logic [OUT_W-1:0]        period_time_o,
  output logic [DUTY_W-1:0]       duty_percent_o
);

  localparam int unsigned XW    = (TICK_WIDTH > OUT_W) ? TICK_WIDTH : OUT_W;
  localparam int unsigned NW    = TICK_WIDTH + DUTY_W;
  localparam int unsigned BIT_W = $clog2(DIV_STEPS);

  function automatic logic [OUT_W-1:0] sat_scale(input logic [PROD_W-1:0] prod,
                                                 input logic hi_nz,
                                                 input logic [TPT_W-1:0] tpt);
    logic [OUT_W-1:0] res;
    if (tpt == '0) begin
      res = '0;
    end else if (hi_nz || (prod[PROD_W-1:OUT_W] != '0)) begin
      res = SAT_MAX;
    end else begin
      res = prod[OUT_W-1:0];
    end
    return res;
  endfunction

  back_state_e           state_q, state_d;
  logic [TICK_WIDTH-1:0] h_q, p_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  hi_q;
  logic [OUT_W-1:0]      on_q;
  logic [NW-1:0]         num_q;
  logic [DUTY_W-1:0]     quo_q;
  logic [BIT_W-1:0]      bit_q;
  logic                  full_q, zero_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_on_q, out_per_q;
  logic [DUTY_W-1:0]     out_duty_q;

  logic [XW-1:0]         h_ext, p_ext;
  logic [NW-1:0]         h_wide, dvs;
  logic                  fin_load;
  logic [DUTY_W-1:0]     duty_val;

  assign h_ext  = XW'(h_q);
  assign p_ext  = XW'(p_q);
  assign h_wide = NW'(h_q);
  assign dvs    = NW'(p_q) << bit_q;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    fin_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!queue_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = ST_MUL_ON;
        end
      end
      ST_MUL_ON:  state_d = ST_MUL_PER;
      ST_MUL_PER: state_d = ST_DIV;
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = fin_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign duty_val = zero_q ? '0 : (full_q ? PERCENT_FULL : quo_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        h_q <= pop_data_i[TICK_WIDTH-1:0];
        p_q <= pop_data_i[2*TICK_WIDTH-1:TICK_WIDTH];
      end
      ST_MUL_ON: begin
        prod_q <= PROD_W'(h_ext[OUT_W-1:0]) * PROD_W'(time_per_tick_i);
        hi_q   <= ((h_ext >> OUT_W) != '0);
        num_q  <= (h_wide << 6) + (h_wide << 5) + (h_wide << 2);
        full_q <= (h_q >= p_q);
        zero_q <= (p_q == '0);
      end
      ST_MUL_PER: begin
        on_q   <= sat_scale(prod_q, hi_q, time_per_tick_i);
        prod_q <= PROD_W'(p_ext[OUT_W-1:0]) * PROD_W'(time_per_tick_i);
        hi_q   <= ((p_ext >> OUT_W) != '0);
        bit_q  <= BIT_W'(DIV_STEPS - 1);
        quo_q  <= '0;
      end
      ST_DIV: begin
        if (num_q >= dvs) begin
          num_q        <= num_q - dvs;
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (fin_load) begin
      out_on_q   <= on_q;
      out_per_q  <= sat_scale(prod_q, hi_q, time_per_tick_i);
      out_duty_q <= duty_val;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign on_time_o      = out_on_q;
  assign period_time_o  = out_per_q;
  assign duty_percent_o = out_duty_q;

  `PCDM_ASSERT_IMP(a_duty_range, out_valid_q, out_duty_q <= PERCENT_FULL, "duty above 100")
  `PCDM_ASSERT_NEXT(a_fin_shows, fin_load, out_valid_q, "loaded result not shown")
  `PCDM_ASSERT_NEXT(a_zero_period, fin_load && zero_q, out_duty_q == '0,
                    "zero period gave nonzero duty")

endmodule

@@ src/pwm_capture_duty_meter.sv @@
// PWM capture duty meter. The input stream carries timer ticks (mode 0) and pin edges
// (mode 1, tuser bit 0 set for rising). Ticks and edges are taken one per clock while the
// two-entry period queue has room; a period-closing rising edge pushes one entry. Each
// entry then passes through the back part (pop, two 32x16 multiplications, seven restoring
// division steps, output load), which pops no new entry until it has loaded the last
// result, so the input stalls only when periods close faster than the back part drains. No
// clearing pass after reset. time_per_tick sits at byte address 0 of the APB port.
// depends on pcdm_pkg, pcdm_front, pcdm_queue, pcdm_back
module pwm_capture_duty_meter
  import pcdm_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] mode, [7:1] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] edge_rising
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] on_time, [63:32] period_time,
                                        // [70:64] duty_percent, [71] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TPT_W-1:0]        tpt_q, tpt_d;
  logic                    reg_hit;
  queue_stat_t             qstat;
  logic                    push, pop;
  logic [2*TICK_WIDTH-1:0] push_data, pop_data;
  logic [OUT_W-1:0]        on_time, period_time;
  logic [DUTY_W-1:0]       duty_percent;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TIME_PER_TICK) && (paddr[1:0] == 2'b00);
  assign tpt_d   = (psel && penable && pwrite && reg_hit) ? pwdata[TPT_W-1:0] : tpt_q;
  assign prdata  = reg_hit ? {{(32-TPT_W){1'b0}}, tpt_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpt_q <= TPT_RESET;
    end else begin
      tpt_q <= tpt_d;
    end
  end

  pcdm_front #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .mode_i       (s_axis_tdata_i[0]),
    .edge_rising_i(s_axis_tuser_i[0]),
    .queue_stat_i (qstat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  pcdm_queue #(
    .DATA_W(2*TICK_WIDTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (qstat)
  );

  pcdm_back #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .time_per_tick_i(tpt_q),
    .queue_stat_i   (qstat),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .on_time_o      (on_time),
    .period_time_o  (period_time),
    .duty_percent_o (duty_percent)
  );

  assign m_axis_tdata_o = {1'b0, duty_percent, period_time, on_time};

endmodule
